// ===== hdl/bsa_pkg.sv =====
// Shared types and codes of the bitmap sector allocator.
package bsa_pkg;

    localparam int OPCODE_W = 2;
    localparam int SECTOR_W = 10;
    localparam int OFFSET_W = 4;
    localparam int STATUS_W = 2;
    localparam int CHUNK_W  = 4;
    localparam int TILE_W   = 10;
    localparam int TOTAL_W  = 11;

    localparam logic [OPCODE_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ACCESS = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [SECTOR_W-1:0] sector_number;
        logic [OFFSET_W-1:0] tile_offset;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SECTOR_W-1:0] granted_sector;
        logic [CHUNK_W-1:0]  chunk_index;
        logic [TILE_W-1:0]   tile_index;
        logic [TOTAL_W-1:0]  total_allocated;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic commit;
    } cmd_t;

endpackage

// ===== hdl/bsa_ctrl.sv =====
// Controller state machine of the bitmap sector allocator.
module bsa_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsa_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;
    logic   commit;
    logic   ready;
    logic   capture;

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign commit   = (state_reg == S_UPDATE) && out_free;
    assign ready    = (state_reg == S_IDLE) || commit;
    assign capture  = req_valid && ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (capture)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (commit)
                begin
                    state_next = capture ? S_CALC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall   = !ready;
    assign rsp_valid   = rsp_valid_reg;
    assign cmd.capture = capture;
    assign cmd.calc    = (state_reg == S_CALC);
    assign cmd.commit  = commit;

endmodule

// ===== hdl/bsa_dp.sv =====
// Datapath of the bitmap sector allocator: bitmap memory, chunk flags, counters.
module bsa_dp
#(
    parameter int CHUNK_SECTORS    = 64,
    parameter int TILES_PER_SECTOR = 16,
    parameter int MAX_CHUNKS       = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  bsa_pkg::cmd_t cmd,
    input  bsa_pkg::req_t req,
    output bsa_pkg::rsp_t rsp
);

    localparam int SPC         = CHUNK_SECTORS;
    localparam int CW          = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int NW          = $clog2(MAX_CHUNKS + 1);
    localparam int SW          = $clog2(SPC);
    localparam int RECIP_SHIFT = 17;
    localparam int RECIP       = (1 << RECIP_SHIFT) / SPC;
    localparam int PROD_W      = bsa_pkg::SECTOR_W + RECIP_SHIFT;

    logic [SPC-1:0] bitmap_mem [MAX_CHUNKS];

    bsa_pkg::req_t req_reg;
    bsa_pkg::rsp_t rsp_reg, rsp_next;

    logic [MAX_CHUNKS-1:0]        full_reg, full_next;
    logic [NW-1:0]                in_use_reg, in_use_next;
    logic [bsa_pkg::TOTAL_W-1:0]  total_reg, total_next;

    logic [CW-1:0]  chunk_reg, chunk_next;
    logic [SW-1:0]  slot_reg;
    logic           in_range_reg;
    logic           found_reg;
    logic [SPC-1:0] rd_data_reg;

    // sector / SPC by reciprocal multiply with one correction step
    logic [PROD_W-1:0]            prod;
    logic [bsa_pkg::SECTOR_W-1:0] quot0, quot, qd, rem0, rem;
    logic                         fix;
    logic                         in_range;

    logic          avail_found;
    logic [CW-1:0] avail_idx;

    logic [SW-1:0]  free_slot;
    logic [SPC-1:0] set_data, clr_data;
    logic           held;
    logic           pool_full;

    logic           wr_en;
    logic [CW-1:0]  wr_addr;
    logic [SPC-1:0] wr_data;

    assign prod  = PROD_W'(req_reg.sector_number) * PROD_W'(RECIP);
    assign quot0 = prod[PROD_W-1:RECIP_SHIFT];
    assign qd    = bsa_pkg::SECTOR_W'(quot0 * bsa_pkg::SECTOR_W'(SPC));
    assign rem0  = req_reg.sector_number - qd;
    assign fix   = rem0 >= bsa_pkg::SECTOR_W'(SPC);
    assign quot  = quot0 + bsa_pkg::SECTOR_W'(fix);
    assign rem   = fix ? rem0 - bsa_pkg::SECTOR_W'(SPC) : rem0;
    assign in_range = 16'(quot) < 16'(in_use_reg);

    always_comb
    begin
        avail_found = 1'b0;
        avail_idx   = '0;
        for (int c = MAX_CHUNKS - 1; c >= 0; c--)
        begin
            if (NW'(c) < in_use_reg && !full_reg[c])
            begin
                avail_found = 1'b1;
                avail_idx   = CW'(c);
            end
        end
    end

    always_comb
    begin
        if (req_reg.opcode == bsa_pkg::OP_ALLOC)
        begin
            chunk_next = avail_found ? avail_idx : in_use_reg[CW-1:0];
        end
        else
        begin
            chunk_next = quot[CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.calc)
        begin
            chunk_reg    <= chunk_next;
            slot_reg     <= rem[SW-1:0];
            in_range_reg <= in_range;
            found_reg    <= avail_found;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            rd_data_reg <= bitmap_mem[chunk_next];
        end
        if (cmd.commit && wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
    end

    always_comb
    begin
        free_slot = '0;
        for (int i = SPC - 1; i >= 0; i--)
        begin
            if (!rd_data_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    assign set_data  = rd_data_reg | (SPC'(1) << free_slot);
    assign clr_data  = rd_data_reg & ~(SPC'(1) << slot_reg);
    assign held      = in_range_reg && rd_data_reg[slot_reg];
    assign pool_full = in_use_reg == NW'(MAX_CHUNKS);

    always_comb
    begin
        full_next   = full_reg;
        in_use_next = in_use_reg;
        total_next  = total_reg;
        wr_en       = 1'b0;
        wr_addr     = chunk_reg;
        wr_data     = clr_data;
        rsp_next    = '0;
        rsp_next.status = bsa_pkg::ST_OK;
        case (req_reg.opcode)
            bsa_pkg::OP_ALLOC:
            begin
                if (found_reg)
                begin
                    wr_en                   = 1'b1;
                    wr_data                 = set_data;
                    full_next[chunk_reg]    = &set_data;
                    total_next              = total_reg + 1'b1;
                    rsp_next.granted_sector = bsa_pkg::SECTOR_W'(
                        32'(chunk_reg) * SPC + 32'(free_slot));
                end
                else if (!pool_full)
                begin
                    wr_en                   = 1'b1;
                    wr_addr                 = in_use_reg[CW-1:0];
                    wr_data                 = SPC'(1);
                    full_next[in_use_reg[CW-1:0]] = 1'b0;
                    in_use_next             = in_use_reg + 1'b1;
                    total_next              = total_reg + 1'b1;
                    rsp_next.granted_sector = bsa_pkg::SECTOR_W'(32'(in_use_reg) * SPC);
                end
                else
                begin
                    rsp_next.status = bsa_pkg::ST_FULL;
                end
            end
            bsa_pkg::OP_FREE:
            begin
                if (held)
                begin
                    wr_en                = 1'b1;
                    full_next[chunk_reg] = 1'b0;
                    total_next           = total_reg - 1'b1;
                end
                else
                begin
                    rsp_next.status = bsa_pkg::ST_NOT_ALLOC;
                end
            end
            bsa_pkg::OP_ACCESS:
            begin
                if (held && 16'(req_reg.tile_offset) < 16'(TILES_PER_SECTOR))
                begin
                    rsp_next.chunk_index = bsa_pkg::CHUNK_W'(chunk_reg);
                    rsp_next.tile_index  = bsa_pkg::TILE_W'(
                        32'(slot_reg) * TILES_PER_SECTOR + 32'(req_reg.tile_offset));
                end
                else
                begin
                    rsp_next.status = bsa_pkg::ST_NOT_ALLOC;
                end
            end
            default:
            begin
                rsp_next.status = bsa_pkg::ST_OK;
            end
        endcase
        rsp_next.total_allocated = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= '0;
            in_use_reg <= '0;
            total_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            full_reg   <= full_next;
            in_use_reg <= in_use_next;
            total_reg  <= total_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== hdl/bitmap_sector_allocator.sv =====
// Top level of the first-fit bitmap sector allocator.
//
// Request channel (req, req_valid, req_stall): one opcode per transfer:
// allocate, free, access or no-op, with a sector number and tile offset.
// Response channel (rsp, rsp_valid, rsp_stall): exactly one response per
// request, in order: status, granted sector, chunk and tile index, and the
// total count of allocated sectors after the request.
// From its transfer a request goes through a calc step (chunk lookup plus
// bitmap read) and then an update step (update and write) that loads the
// response into the output register. The next request is taken in the
// cycle its predecessor writes back, not before, since each request holds
// the bitmap memory for its read-modify-write.
// The output register lets the next request enter while a response waits.
// When rsp_stall holds, the response stays and the pending request waits
// in its update step; req_stall rises until the response drains.
// Reset clears the chunk-full flags, open-chunk count and total; bitmap
// memory needs no clearing since a chunk is written whole when opened.
module bitmap_sector_allocator
#(
    parameter int CHUNK_SECTORS    = 64,
    parameter int TILES_PER_SECTOR = 16,
    parameter int MAX_CHUNKS       = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bsa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsa_pkg::rsp_t rsp
);

    bsa_pkg::cmd_t cmd;

    bsa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    bsa_dp
    #(
        .CHUNK_SECTORS    (CHUNK_SECTORS),
        .TILES_PER_SECTOR (TILES_PER_SECTOR),
        .MAX_CHUNKS       (MAX_CHUNKS)
    )
    u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

// ===== verif/bsa_checker.sv =====
// Checker for the bitmap sector allocator: predicts each response and compares it.
module bsa_checker
#(
    parameter int CHUNK_SECTORS    = 64,
    parameter int TILES_PER_SECTOR = 16,
    parameter int MAX_CHUNKS       = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  bsa_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  bsa_pkg::rsp_t rsp,
    output int            fail_count,
    output int            outstanding
);

    logic [63:0]   alloc_map [MAX_CHUNKS];
    logic [6:0]    slot_count [MAX_CHUNKS];
    int            open_chunks;
    bsa_pkg::rsp_t due_rsp [$];
    int            mismatches;

    assign fail_count = mismatches;

    function automatic bsa_pkg::rsp_t apply_request(input bsa_pkg::req_t r);
        bsa_pkg::rsp_t o;
        int   c;
        int   s;
        int   ch;
        int   sl;
        int   sum;
        bit   done;
        bit   held;
        o  = '0;
        ch = int'(r.sector_number) / CHUNK_SECTORS;
        sl = int'(r.sector_number) % CHUNK_SECTORS;
        held = 1'b0;
        if (ch < MAX_CHUNKS && ch < open_chunks)
            held = alloc_map[ch][sl];
        case (r.opcode)
            bsa_pkg::OP_ALLOC:
            begin
                done = 1'b0;
                for (c = 0; c < open_chunks && !done; c++)
                begin
                    if (int'(slot_count[c]) < CHUNK_SECTORS)
                    begin
                        for (s = 0; s < CHUNK_SECTORS && !done; s++)
                        begin
                            if (!alloc_map[c][s])
                            begin
                                alloc_map[c][s]  = 1'b1;
                                slot_count[c]    = slot_count[c] + 7'd1;
                                o.granted_sector = bsa_pkg::SECTOR_W'(c * CHUNK_SECTORS + s);
                                done             = 1'b1;
                            end
                        end
                    end
                end
                if (!done)
                begin
                    if (open_chunks < MAX_CHUNKS)
                    begin
                        alloc_map[open_chunks]  = 64'd1;
                        slot_count[open_chunks] = 7'd1;
                        o.granted_sector        = bsa_pkg::SECTOR_W'(
                            open_chunks * CHUNK_SECTORS);
                        open_chunks++;
                    end
                    else
                    begin
                        o.status = bsa_pkg::ST_FULL;
                    end
                end
            end
            bsa_pkg::OP_FREE:
            begin
                if (held)
                begin
                    alloc_map[ch][sl] = 1'b0;
                    if (slot_count[ch] > 7'd0)
                        slot_count[ch] = slot_count[ch] - 7'd1;
                end
                else
                begin
                    o.status = bsa_pkg::ST_NOT_ALLOC;
                end
            end
            bsa_pkg::OP_ACCESS:
            begin
                if (held && int'(r.tile_offset) < TILES_PER_SECTOR)
                begin
                    o.chunk_index = bsa_pkg::CHUNK_W'(ch);
                    o.tile_index  = bsa_pkg::TILE_W'(
                        sl * TILES_PER_SECTOR + int'(r.tile_offset));
                end
                else
                begin
                    o.status = bsa_pkg::ST_NOT_ALLOC;
                end
            end
            default:
            begin
            end
        endcase
        sum = 0;
        for (c = 0; c < MAX_CHUNKS; c++)
            sum += int'(slot_count[c]);
        o.total_allocated = bsa_pkg::TOTAL_W'(sum);
        return o;
    endfunction

    task automatic check_field(input string tag, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bsa_pkg::rsp_t want;
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CHUNKS; c++)
            begin
                alloc_map[c]  = '0;
                slot_count[c] = '0;
            end
            open_chunks = 0;
            due_rsp.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                begin
                    $display("%0t: response transfer with none expected, status %0d",
                             $time, rsp.status);
                    mismatches++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("granted_sector", 16'(want.granted_sector),
                                16'(rsp.granted_sector));
                    check_field("chunk_index", 16'(want.chunk_index),
                                16'(rsp.chunk_index));
                    check_field("tile_index", 16'(want.tile_index),
                                16'(rsp.tile_index));
                    check_field("total_allocated", 16'(want.total_allocated),
                                16'(rsp.total_allocated));
                end
            end
            if (req_valid && !req_stall)
                due_rsp.insert(due_rsp.size(), apply_request(req));
            outstanding <= due_rsp.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the bitmap sector allocator: stimulus, idling, response stalls and verdict.
module tb;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    bsa_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    bsa_pkg::rsp_t rsp;
    int            fail_count;
    int            outstanding;
    int            idle_pct;
    int            stall_pct;
    int            hi_water;

    bitmap_sector_allocator u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bsa_checker u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
        rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    task automatic send(input logic [1:0] op, input int sector, input int offset);
        bsa_pkg::req_t r;
        r.opcode        = op;
        r.sector_number = bsa_pkg::SECTOR_W'(sector);
        r.tile_offset   = bsa_pkg::OFFSET_W'(offset);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (op == bsa_pkg::OP_ALLOC && hi_water < 1023)
            hi_water++;
    endtask

    task automatic random_items(input int count, input int alloc_pct);
        int sector;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 80)
                sector = $urandom_range(hi_water, 0);
            else
                sector = $urandom_range(1023, 0);
            pick = $urandom_range(9);
            if ($urandom_range(99) < alloc_pct)
                send(bsa_pkg::OP_ALLOC, $urandom_range(1023, 0), $urandom_range(15, 0));
            else if (pick == 0)
                send(bsa_pkg::OP_NOP, $urandom_range(1023, 0), $urandom_range(15, 0));
            else if (pick < 5)
                send(bsa_pkg::OP_FREE, sector, $urandom_range(15, 0));
            else
                send(bsa_pkg::OP_ACCESS, sector, $urandom_range(15, 0));
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        idle_pct  = 0;
        stall_pct = 0;
        hi_water  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pool, first grants, hole refill, unopened chunks
        send(bsa_pkg::OP_ACCESS, 0, 0);
        send(bsa_pkg::OP_FREE, 0, 0);
        send(bsa_pkg::OP_NOP, 1023, 15);
        send(bsa_pkg::OP_ALLOC, 0, 0);
        send(bsa_pkg::OP_ALLOC, 0, 0);
        send(bsa_pkg::OP_ALLOC, 0, 0);
        send(bsa_pkg::OP_ACCESS, 2, 15);
        send(bsa_pkg::OP_ACCESS, 0, 0);
        send(bsa_pkg::OP_FREE, 1, 0);
        send(bsa_pkg::OP_FREE, 1, 0);
        send(bsa_pkg::OP_ACCESS, 1, 5);
        send(bsa_pkg::OP_ALLOC, 0, 0);
        send(bsa_pkg::OP_ACCESS, 1023, 15);
        send(bsa_pkg::OP_FREE, 1023, 0);
        send(bsa_pkg::OP_ACCESS, 64, 3);
        send(bsa_pkg::OP_ACCESS, 63, 9);
        send(bsa_pkg::OP_ALLOC, 1023, 15);
        send(bsa_pkg::OP_NOP, 0, 0);

        random_items(250, 60);

        idle_pct = 48;
        random_items(250, 55);
        // fill the whole pool and run past it
        for (int i = 0; i < 1030; i++)
            send(bsa_pkg::OP_ALLOC, $urandom_range(1023, 0), $urandom_range(15, 0));

        idle_pct  = 0;
        stall_pct = 48;
        random_items(250, 40);

        idle_pct  = 21;
        stall_pct = 21;
        random_items(250, 40);

        req_valid <= 1'b0;
        stall_pct = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bsa_pkg.sv
hdl/bsa_ctrl.sv
hdl/bsa_dp.sv
hdl/bitmap_sector_allocator.sv
verif/bsa_checker.sv
verif/tb.sv
